>>> hdl/urph_pkg.sv
// urph_pkg: shared types and codes for the undo/redo point history block
// no dependencies; used by the interfaces, the top level and the checker

package urph_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;

  // operation requested on the history
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_UNDO   = 2'd1,
    MODE_REDO   = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  // response status
  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 3'd0,
    STAT_POOL_FULL = 3'd1,
    STAT_NO_UNDO   = 3'd2,
    STAT_NO_REDO   = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE        = 3'd0,
    S_PUSH_NEW    = 3'd1,
    S_MOVE        = 3'd2,
    S_DEL_PREV    = 3'd3,
    S_DEL_NEXT_RD = 3'd4,
    S_DEL_NEXT    = 3'd5,
    S_DONE        = 3'd6
  } fsm_state_e;

endpackage

>>> hdl/urph_if.sv
// urph_req_if / urph_rsp_if: valid/ready channels for requests and responses
// depends on urph_pkg for field widths

interface urph_req_if;
  logic                          valid;
  logic                          ready;
  logic [urph_pkg::ModeW-1:0]    mode;
  logic [urph_pkg::CoordW-1:0]   point_x;
  logic [urph_pkg::CoordW-1:0]   point_y;

  modport source (output valid, output mode, output point_x, output point_y, input ready);
  modport sink   (input valid, input mode, input point_x, input point_y, output ready);
endinterface

interface urph_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [urph_pkg::StatusW-1:0]  status;
  logic                          cursor_valid;
  logic [urph_pkg::CoordW-1:0]   cursor_x;
  logic [urph_pkg::CoordW-1:0]   cursor_y;

  modport source (output valid, output status, output cursor_valid, output cursor_x,
                  output cursor_y, input ready);
  modport sink   (input valid, input status, input cursor_valid, input cursor_x,
                  input cursor_y, output ready);
endinterface

>>> hdl/undo_redo_point_history.sv
// undo_redo_point_history: undo/redo history of (x,y) points as a doubly linked list
// depends on urph_pkg and the request/response interfaces in urph_if.sv
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+--------------------------------------------
//   req_i   | in  | valid/ready | mode, point_x, point_y
//   rsp_o   | out | valid/ready | status, cursor_valid, cursor_x, cursor_y
//
// one request at a time; failed moves, empty or single-node delete and a push into a
// full pool go straight to S_DONE; push passes S_PUSH_NEW, undo/redo S_MOVE, delete
// with one neighbor S_DEL_PREV or S_DEL_NEXT, with both S_DEL_PREV, S_DEL_NEXT_RD,
// S_DEL_NEXT (read and rewrite both through the single node memory port)
// the response sits in an output register; a new request is accepted while it waits
// reset clears the pointers and the allocation count at once, no clearing pass
// a stalled response only holds the sequencer in its final state

module undo_redo_point_history #(
  parameter int unsigned POOL_NODES = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  urph_req_if.sink   req_i,
  urph_rsp_if.source rsp_o
);

  localparam int unsigned IdxW   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  // one extra code above the last index marks "no node"
  localparam int unsigned PtrW   = $clog2(POOL_NODES + 1);
  localparam int unsigned CW     = urph_pkg::CoordW;
  localparam int unsigned EntryW = 2 * CW + 2 * PtrW;
  localparam logic [PtrW-1:0] NonePtr = PtrW'(POOL_NODES);

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CW-1:0]   coord_t;

  function automatic logic is_node(ptr_t p);
    return p < NonePtr;
  endfunction

  // ---------------------------------------------------------------------------
  // node memory: entry = {x, y, next, prev}, single port, registered read
  // ---------------------------------------------------------------------------
  logic [EntryW-1:0] node_mem [POOL_NODES];
  logic              mem_en;
  logic              mem_we;
  logic [IdxW-1:0]   mem_addr;
  logic [EntryW-1:0] mem_wdata;
  logic [EntryW-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      if (mem_we) begin
        node_mem[mem_addr] <= mem_wdata;
      end else begin
        mem_rdata_q <= node_mem[mem_addr];
      end
    end
  end

  // fields of the entry read last cycle
  coord_t rd_x;
  coord_t rd_y;
  ptr_t   rd_next;
  ptr_t   rd_prev;

  assign rd_x    = mem_rdata_q[EntryW-1 -: CW];
  assign rd_y    = mem_rdata_q[EntryW-CW-1 -: CW];
  assign rd_next = mem_rdata_q[2*PtrW-1 -: PtrW];
  assign rd_prev = mem_rdata_q[PtrW-1:0];

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  urph_pkg::fsm_state_e state_q, state_d;

  // list pointers and allocator
  ptr_t cursor_q, cursor_d;
  ptr_t newest_q, newest_d;
  ptr_t oldest_q, oldest_d;
  ptr_t alloc_q,  alloc_d;

  // copy of the cursor node, kept coherent with every write to it
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  ptr_t   cur_next_q, cur_next_d;
  ptr_t   cur_prev_q, cur_prev_d;

  // per-request scratch
  ptr_t   nx_q, nx_d;
  ptr_t   pv_q, pv_d;
  coord_t px_q, px_d;
  coord_t py_q, py_d;
  urph_pkg::status_e status_q, status_d;

  // response register
  logic              rsp_valid_q, rsp_valid_d;
  urph_pkg::status_e rsp_status_q, rsp_status_d;
  logic              rsp_cv_q, rsp_cv_d;
  coord_t            rsp_x_q, rsp_x_d;
  coord_t            rsp_y_q, rsp_y_d;

  logic              req_fire;
  logic              cur_is_node;
  logic              pool_full;
  logic              trunc;
  logic              rsp_free;
  urph_pkg::mode_e   req_mode;

  assign req_i.ready = (state_q == urph_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_mode    = urph_pkg::mode_e'(req_i.mode);
  assign cur_is_node = is_node(cursor_q);
  assign pool_full   = (alloc_q == NonePtr);
  // cursor behind the newest node: push drops the redo tail
  assign trunc       = (cursor_q != newest_q);
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      urph_pkg::S_IDLE: begin
        if (req_fire) begin
          case (req_mode)
            urph_pkg::MODE_PUSH: begin
              state_d = pool_full ? urph_pkg::S_DONE : urph_pkg::S_PUSH_NEW;
            end
            urph_pkg::MODE_UNDO: begin
              state_d = (cur_is_node && is_node(cur_prev_q)) ? urph_pkg::S_MOVE
                                                             : urph_pkg::S_DONE;
            end
            urph_pkg::MODE_REDO: begin
              state_d = (cur_is_node && is_node(cur_next_q)) ? urph_pkg::S_MOVE
                                                             : urph_pkg::S_DONE;
            end
            urph_pkg::MODE_DELETE: begin
              if (!cur_is_node) begin
                state_d = urph_pkg::S_DONE;
              end else if (is_node(cur_prev_q)) begin
                state_d = urph_pkg::S_DEL_PREV;
              end else if (is_node(cur_next_q)) begin
                state_d = urph_pkg::S_DEL_NEXT;
              end else begin
                state_d = urph_pkg::S_DONE;
              end
            end
            default: state_d = urph_pkg::S_DONE;
          endcase
        end
      end
      urph_pkg::S_PUSH_NEW:    state_d = urph_pkg::S_DONE;
      urph_pkg::S_MOVE:        state_d = urph_pkg::S_DONE;
      urph_pkg::S_DEL_PREV: begin
        state_d = is_node(nx_q) ? urph_pkg::S_DEL_NEXT_RD : urph_pkg::S_DONE;
      end
      urph_pkg::S_DEL_NEXT_RD: state_d = urph_pkg::S_DEL_NEXT;
      urph_pkg::S_DEL_NEXT:    state_d = urph_pkg::S_DONE;
      urph_pkg::S_DONE: begin
        if (rsp_free) begin
          state_d = urph_pkg::S_IDLE;
        end
      end
      default: state_d = urph_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and memory port
  // ---------------------------------------------------------------------------
  always_comb begin
    cursor_d     = cursor_q;
    newest_d     = newest_q;
    oldest_d     = oldest_q;
    alloc_d      = alloc_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    cur_next_d   = cur_next_q;
    cur_prev_d   = cur_prev_q;
    nx_d         = nx_q;
    pv_d         = pv_q;
    px_d         = px_q;
    py_d         = py_q;
    status_d     = status_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_cv_d     = rsp_cv_q;
    rsp_x_d      = rsp_x_q;
    rsp_y_d      = rsp_y_q;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = cursor_q[IdxW-1:0];
    mem_wdata    = '0;

    case (state_q)
      urph_pkg::S_IDLE: begin
        if (req_fire) begin
          px_d     = req_i.point_x;
          py_d     = req_i.point_y;
          status_d = urph_pkg::STAT_OK;
          case (req_mode)
            urph_pkg::MODE_PUSH: begin
              // one write to the cursor node covers both cutting the redo
              // tail and linking the new node behind it
              if (cur_is_node && (trunc || !pool_full)) begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = cursor_q[IdxW-1:0];
                cur_next_d = pool_full ? NonePtr : alloc_q;
                mem_wdata  = {cur_x_q, cur_y_q, cur_next_d, cur_prev_q};
              end
              if (trunc) begin
                newest_d = cursor_q;
              end
              if (pool_full) begin
                status_d = urph_pkg::STAT_POOL_FULL;
              end
            end
            urph_pkg::MODE_UNDO: begin
              if (!cur_is_node) begin
                status_d = urph_pkg::STAT_EMPTY;
              end else if (is_node(cur_prev_q)) begin
                mem_en   = 1'b1;
                mem_addr = cur_prev_q[IdxW-1:0];
                cursor_d = cur_prev_q;
              end else begin
                status_d = urph_pkg::STAT_NO_UNDO;
              end
            end
            urph_pkg::MODE_REDO: begin
              if (!cur_is_node) begin
                status_d = urph_pkg::STAT_EMPTY;
              end else if (is_node(cur_next_q)) begin
                mem_en   = 1'b1;
                mem_addr = cur_next_q[IdxW-1:0];
                cursor_d = cur_next_q;
              end else begin
                status_d = urph_pkg::STAT_NO_REDO;
              end
            end
            urph_pkg::MODE_DELETE: begin
              if (!cur_is_node) begin
                status_d = urph_pkg::STAT_EMPTY;
              end else begin
                nx_d = cur_next_q;
                pv_d = cur_prev_q;
                // end pointers move when the cursor node sits at an end
                if (!is_node(cur_prev_q)) begin
                  oldest_d = cur_next_q;
                end
                if (!is_node(cur_next_q)) begin
                  newest_d = cur_prev_q;
                end
                cursor_d = is_node(cur_next_q) ? cur_next_q : cur_prev_q;
                // start the read of the first neighbor to relink
                if (is_node(cur_prev_q)) begin
                  mem_en   = 1'b1;
                  mem_addr = cur_prev_q[IdxW-1:0];
                end else if (is_node(cur_next_q)) begin
                  mem_en   = 1'b1;
                  mem_addr = cur_next_q[IdxW-1:0];
                end
              end
            end
            default: status_d = urph_pkg::STAT_OK;
          endcase
        end
      end

      urph_pkg::S_PUSH_NEW: begin
        // new node at the bump pointer, linked behind the cursor
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = alloc_q[IdxW-1:0];
        mem_wdata  = {px_q, py_q, NonePtr, cursor_q};
        cur_x_d    = px_q;
        cur_y_d    = py_q;
        cur_next_d = NonePtr;
        cur_prev_d = cursor_q;
        cursor_d   = alloc_q;
        newest_d   = alloc_q;
        if (!is_node(oldest_q)) begin
          oldest_d = alloc_q;
        end
        alloc_d    = alloc_q + PtrW'(1);
      end

      urph_pkg::S_MOVE: begin
        cur_x_d    = rd_x;
        cur_y_d    = rd_y;
        cur_next_d = rd_next;
        cur_prev_d = rd_prev;
      end

      urph_pkg::S_DEL_PREV: begin
        // predecessor skips the deleted node
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = pv_q[IdxW-1:0];
        mem_wdata = {rd_x, rd_y, nx_q, rd_prev};
        if (!is_node(nx_q)) begin
          // no successor: the predecessor becomes the cursor
          cur_x_d    = rd_x;
          cur_y_d    = rd_y;
          cur_next_d = nx_q;
          cur_prev_d = rd_prev;
        end
      end

      urph_pkg::S_DEL_NEXT_RD: begin
        mem_en   = 1'b1;
        mem_addr = nx_q[IdxW-1:0];
      end

      urph_pkg::S_DEL_NEXT: begin
        // successor points back past the deleted node and becomes the cursor
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = nx_q[IdxW-1:0];
        mem_wdata  = {rd_x, rd_y, rd_next, pv_q};
        cur_x_d    = rd_x;
        cur_y_d    = rd_y;
        cur_next_d = rd_next;
        cur_prev_d = pv_q;
      end

      urph_pkg::S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_cv_d     = cur_is_node;
          rsp_x_d      = cur_is_node ? cur_x_q : '0;
          rsp_y_d      = cur_is_node ? cur_y_q : '0;
        end
      end

      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= urph_pkg::S_IDLE;
      cursor_q    <= NonePtr;
      newest_q    <= NonePtr;
      oldest_q    <= NonePtr;
      alloc_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      alloc_q     <= alloc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    cur_next_q   <= cur_next_d;
    cur_prev_q   <= cur_prev_d;
    nx_q         <= nx_d;
    pv_q         <= pv_d;
    px_q         <= px_d;
    py_q         <= py_d;
    status_q     <= status_d;
    rsp_status_q <= rsp_status_d;
    rsp_cv_q     <= rsp_cv_d;
    rsp_x_q      <= rsp_x_d;
    rsp_y_q      <= rsp_y_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.cursor_valid = rsp_cv_q;
  assign rsp_o.cursor_x     = rsp_x_q;
  assign rsp_o.cursor_y     = rsp_y_q;

endmodule

>>> hdl/urph_checker.sv
// urph_checker: port-level checks for undo_redo_point_history, bound to the top level
// depends on urph_pkg and undo_redo_point_history

module urph_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [urph_pkg::StatusW-1:0]  rsp_status_i,
  input logic                          rsp_cursor_valid_i,
  input logic [urph_pkg::CoordW-1:0]   rsp_cursor_x_i,
  input logic [urph_pkg::CoordW-1:0]   rsp_cursor_y_i
);

  // one request in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous one still in flight");

  // no cursor node means a cleared point
  a_cleared_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_cursor_valid_i |-> rsp_cursor_x_i == '0 && rsp_cursor_y_i == '0)
    else $error("point reported without a cursor node");

  // empty history never reports a cursor
  a_empty_no_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == urph_pkg::STAT_EMPTY |-> !rsp_cursor_valid_i)
    else $error("empty status with a cursor node");

  // failed undo or redo keeps a cursor node
  a_boundary_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == urph_pkg::STAT_NO_UNDO ||
                    rsp_status_i == urph_pkg::STAT_NO_REDO) |-> rsp_cursor_valid_i)
    else $error("no undo/redo status without a cursor node");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_cursor_valid_i) && $stable(rsp_cursor_x_i) && $stable(rsp_cursor_y_i))
    else $error("stalled response changed");

endmodule

bind undo_redo_point_history urph_checker u_urph_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_cursor_valid_i (rsp_o.cursor_valid),
  .rsp_cursor_x_i     (rsp_o.cursor_x),
  .rsp_cursor_y_i     (rsp_o.cursor_y)
);

>>> dv/undo_redo_point_history_test.sv
// undo_redo_point_history_test: self-checking bench for the undo/redo point history
// depends on urph_pkg, urph_req_if/urph_rsp_if and the undo_redo_point_history top level

`timescale 1ns / 1ps

module undo_redo_point_history_test;

  // pool size of the block under test and the none pointer it uses
  localparam int unsigned POOL    = 256;
  localparam logic [8:0]  NIL     = 9'(POOL);
  localparam int unsigned NRANDOM = 1000;

  // one request as the bench sees it
  typedef struct packed {
    urph_pkg::mode_e mode;
    logic [7:0]      x;
    logic [7:0]      y;
  } hist_req_t;

  // one response: status plus the point under the cursor
  typedef struct packed {
    urph_pkg::status_e status;
    logic              cursor_valid;
    logic [7:0]        cursor_x;
    logic [7:0]        cursor_y;
  } hist_rsp_t;

  // one list node of the shadow history
  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [8:0]  next_p;
    logic [8:0]  prev_p;
  } hist_node_t;

  logic clk_i;
  logic rst_ni;

  urph_req_if req_if ();
  urph_rsp_if rsp_if ();

  undo_redo_point_history #(
    .POOL_NODES(POOL)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the history: node pool, bump allocator and the three pointers
  // ---------------------------------------------------------------------------
  hist_node_t  hist_mem [POOL];
  logic [8:0]  alloc_cnt;
  logic [8:0]  oldest_p;
  logic [8:0]  newest_p;
  logic [8:0]  cur_p;
  int unsigned status_seen [5];

  hist_req_t request_q [$];     // requests still to be offered
  hist_rsp_t cursor_expect_q [$]; // cursor responses still owed by the block

  int unsigned mismatch_cnt;
  int unsigned accepted_cnt;
  int unsigned answered_cnt;

  function automatic logic is_node(logic [8:0] p);
    return p < POOL;
  endfunction

  // apply one accepted request to the shadow history and work out the response
  task automatic advance_history(input hist_req_t rq, output hist_rsp_t rs);
    logic [8:0] nx;
    logic [8:0] pv;
    logic [8:0] nn;
    urph_pkg::status_e st;
    st = urph_pkg::STAT_OK;
    case (rq.mode)
      urph_pkg::MODE_PUSH: begin
        // the redo tail goes first, even if the pool turns out to be full
        if (cur_p != newest_p) begin
          newest_p = cur_p;
          if (is_node(cur_p)) hist_mem[cur_p[7:0]].next_p = NIL;
        end
        if (alloc_cnt >= POOL) begin
          st = urph_pkg::STAT_POOL_FULL;
        end else begin
          nn = alloc_cnt;
          alloc_cnt = alloc_cnt + 9'd1;
          hist_mem[nn[7:0]].x      = rq.x;
          hist_mem[nn[7:0]].y      = rq.y;
          hist_mem[nn[7:0]].next_p = NIL;
          hist_mem[nn[7:0]].prev_p = is_node(newest_p) ? newest_p : NIL;
          if (is_node(newest_p)) hist_mem[newest_p[7:0]].next_p = nn;
          newest_p = nn;
          cur_p    = nn;
          if (!is_node(oldest_p)) oldest_p = nn;
        end
      end
      urph_pkg::MODE_UNDO: begin
        if (!is_node(cur_p)) st = urph_pkg::STAT_EMPTY;
        else if (is_node(hist_mem[cur_p[7:0]].prev_p)) cur_p = hist_mem[cur_p[7:0]].prev_p;
        else st = urph_pkg::STAT_NO_UNDO;
      end
      urph_pkg::MODE_REDO: begin
        if (!is_node(cur_p)) st = urph_pkg::STAT_EMPTY;
        else if (is_node(hist_mem[cur_p[7:0]].next_p)) cur_p = hist_mem[cur_p[7:0]].next_p;
        else st = urph_pkg::STAT_NO_REDO;
      end
      default: begin
        // unlink the cursor node, cursor moves to successor, else predecessor
        if (!is_node(cur_p)) begin
          st = urph_pkg::STAT_EMPTY;
        end else begin
          nx = hist_mem[cur_p[7:0]].next_p;
          pv = hist_mem[cur_p[7:0]].prev_p;
          if (is_node(pv)) hist_mem[pv[7:0]].next_p = nx;
          else oldest_p = is_node(nx) ? nx : NIL;
          if (is_node(nx)) hist_mem[nx[7:0]].prev_p = pv;
          else newest_p = is_node(pv) ? pv : NIL;
          if (is_node(nx)) cur_p = nx;
          else if (is_node(pv)) cur_p = pv;
          else cur_p = NIL;
        end
      end
    endcase
    rs.status       = st;
    rs.cursor_valid = is_node(cur_p);
    rs.cursor_x     = is_node(cur_p) ? hist_mem[cur_p[7:0]].x : 8'd0;
    rs.cursor_y     = is_node(cur_p) ? hist_mem[cur_p[7:0]].y : 8'd0;
    status_seen[st] = status_seen[st] + 1;
  endtask

  // one line per mismatch, and a running count
  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_cnt = mismatch_cnt + 1;
  endtask

  task automatic queue_request(input urph_pkg::mode_e m, input logic [7:0] x,
                               input logic [7:0] y);
    hist_req_t rq;
    rq.mode = m;
    rq.x    = x;
    rq.y    = y;
    request_q.push_back(rq);
  endtask

  // ---------------------------------------------------------------------------
  // clock and the single reset at the start
  // ---------------------------------------------------------------------------
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  hist_req_t   took_rq;
  hist_req_t   next_rq;
  hist_rsp_t   owed_rsp;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.mode    <= urph_pkg::MODE_PUSH;
      req_if.point_x <= 8'd0;
      req_if.point_y <= 8'd0;
      burst_left     = 0;
      gap_left       = 0;
      alloc_cnt      = 9'd0;
      oldest_p       = NIL;
      newest_p       = NIL;
      cur_p          = NIL;
    end else begin
      // a request taken at this edge is folded into the shadow history right away
      if (req_if.valid && req_if.ready) begin
        took_rq.mode = urph_pkg::mode_e'(req_if.mode);
        took_rq.x    = req_if.point_x;
        took_rq.y    = req_if.point_y;
        advance_history(took_rq, owed_rsp);
        cursor_expect_q.push_back(owed_rsp);
        accepted_cnt = accepted_cnt + 1;
      end
      // the request lane is free when nothing is offered or the offer just went in
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          next_rq = request_q.pop_front();
          req_if.valid   <= 1'b1;
          req_if.mode    <= next_rq.mode;
          req_if.point_x <= next_rq.x;
          req_if.point_y <= next_rq.y;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            // end of a burst: sometimes run straight on, otherwise pause a while
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response side: a stall style that changes every so often, plus one long hold
  // ---------------------------------------------------------------------------
  int unsigned rx_cycles;
  int unsigned stall_style;
  int unsigned hold_cycles;
  int unsigned hold_left;
  logic        hold_done;

  // long hold-off counted in its own process; the driver keeps offering meanwhile
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      hold_cycles <= hold_cycles + 1;
      if (!hold_done && hold_cycles == 1500) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_cycles    = 0;
      stall_style  = 0;
    end else begin
      rx_cycles = rx_cycles + 1;
      if (rx_cycles % 50 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else begin
        case (stall_style)
          0:       rsp_if.ready <= 1'b1;                         // always taking
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));     // coin flip
          2:       rsp_if.ready <= ($urandom_range(0, 7) != 0);  // rare stalls
          default: rsp_if.ready <= (rx_cycles % 5 == 0);         // slow fixed beat
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response monitor: every response against the oldest owed cursor response
  // ---------------------------------------------------------------------------
  hist_rsp_t want_rsp;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      answered_cnt = answered_cnt + 1;
      if (cursor_expect_q.size() == 0) begin
        flag_mismatch($sformatf("response #%0d with no request outstanding", answered_cnt));
      end else begin
        want_rsp = cursor_expect_q.pop_front();
        if (rsp_if.status !== want_rsp.status)
          flag_mismatch($sformatf("response #%0d status %0d, want %0d", answered_cnt,
                                  rsp_if.status, want_rsp.status));
        if (rsp_if.cursor_valid !== want_rsp.cursor_valid)
          flag_mismatch($sformatf("response #%0d cursor_valid %0b, want %0b", answered_cnt,
                                  rsp_if.cursor_valid, want_rsp.cursor_valid));
        if (rsp_if.cursor_x !== want_rsp.cursor_x)
          flag_mismatch($sformatf("response #%0d cursor_x %0d, want %0d", answered_cnt,
                                  rsp_if.cursor_x, want_rsp.cursor_x));
        if (rsp_if.cursor_y !== want_rsp.cursor_y)
          flag_mismatch($sformatf("response #%0d cursor_y %0d, want %0d", answered_cnt,
                                  rsp_if.cursor_y, want_rsp.cursor_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  int unsigned pick;

  initial begin
    mismatch_cnt = 0;
    accepted_cnt = 0;
    answered_cnt = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // moves and delete on an empty history
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_REDO,   8'hff, 8'hff);
    queue_request(urph_pkg::MODE_DELETE, 8'h00, 8'h00);
    // three pushes with extreme and alternating coordinates
    queue_request(urph_pkg::MODE_PUSH,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_PUSH,   8'hff, 8'hff);
    queue_request(urph_pkg::MODE_PUSH,   8'haa, 8'h55);
    // walk back past the oldest node, then forward past the newest
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_REDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_REDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_REDO,   8'h00, 8'h00);
    // push from the oldest node cuts the redo tail
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_PUSH,   8'h55, 8'haa);
    // delete the oldest node, cursor goes to its successor
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_DELETE, 8'h00, 8'h00);
    // delete the oldest node again, then the last node, then twice more on an empty history
    queue_request(urph_pkg::MODE_PUSH,   8'h12, 8'h34);
    queue_request(urph_pkg::MODE_UNDO,   8'h00, 8'h00);
    queue_request(urph_pkg::MODE_DELETE, 8'h00, 8'h00);
    queue_request(urph_pkg::MODE_DELETE, 8'h00, 8'h00);
    queue_request(urph_pkg::MODE_DELETE, 8'h00, 8'h00);
    queue_request(urph_pkg::MODE_DELETE, 8'h00, 8'h00);
    queue_request(urph_pkg::MODE_PUSH,   8'h01, 8'h80);

    // random mix leaning on push so the pool fills and later pushes bounce off it
    for (int n = 0; n < NRANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      queue_request(urph_pkg::MODE_PUSH, 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
      else if (pick < 65) queue_request(urph_pkg::MODE_UNDO, 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
      else if (pick < 80) queue_request(urph_pkg::MODE_REDO, 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
      else                queue_request(urph_pkg::MODE_DELETE, 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
    end

    // wait until every request went in and every response came back
    @(posedge rst_ni);
    while (request_q.size() != 0 || req_if.valid || cursor_expect_q.size() != 0)
      @(negedge clk_i);
    // keep the clock running to catch any stray response
    repeat (10) @(negedge clk_i);

    $display("run covered %0d requests, %0d responses, %0d nodes allocated", accepted_cnt,
             answered_cnt, alloc_cnt);
    $display("status mix: ok %0d, pool full %0d, no undo %0d, no redo %0d, empty %0d",
             status_seen[urph_pkg::STAT_OK], status_seen[urph_pkg::STAT_POOL_FULL],
             status_seen[urph_pkg::STAT_NO_UNDO], status_seen[urph_pkg::STAT_NO_REDO],
             status_seen[urph_pkg::STAT_EMPTY]);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout with %0d responses still owed", cursor_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/urph_pkg.sv
hdl/urph_if.sv
hdl/undo_redo_point_history.sv
hdl/urph_checker.sv
dv/undo_redo_point_history_test.sv
